// ----- src/qmt_pkg.sv -----
// Shared types, constants and arithmetic helpers for the quaternion matrix transform.
// No dependencies.
`default_nettype none
package qmt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int MAT_DEPTH = 16;

    typedef enum logic [1:0] {
        ACT_LOAD      = 2'd0,
        ACT_ROTATE    = 2'd1,
        ACT_TRANSFORM = 2'd2,
        ACT_NONE      = 2'd3
    } action_t;

    // Accumulator operand sources.
    typedef enum logic [2:0] {
        ASRC_ZERO  = 3'd0,
        ASRC_PROD  = 3'd1,
        ASRC_PROD2 = 3'd2,
        ASRC_NPROD2 = 3'd3,
        ASRC_ONE   = 3'd4,
        ASRC_MAT   = 3'd5
    } asrc_t;

    // Multiplier operand sources.
    typedef enum logic [3:0] {
        MSRC_QW = 4'd0, MSRC_QX = 4'd1, MSRC_QY = 4'd2, MSRC_QZ = 4'd3,
        MSRC_PX = 4'd4, MSRC_PY = 4'd5, MSRC_ROT = 4'd6, MSRC_MAT = 4'd7
    } msrc_t;

    typedef struct packed {
        logic        mul_en;     // Register a new product.
        msrc_t       mul_a;
        msrc_t       mul_b;
        logic [3:0]  rot_idx;    // Rotation element read by the multiplier.
        logic [3:0]  mat_idx;    // Matrix element read by multiplier or adder.
        logic        acc_clr;
        logic        acc_en;
        asrc_t       acc_src;
        logic        rot_wr;     // Store saturated sum into rotation scratch.
        logic [3:0]  rot_wr_idx;
        logic        res_wr;     // Store saturated sum into result scratch.
        logic [3:0]  res_wr_idx;
        logic        commit;     // Copy result scratch into the matrix.
        logic        load_wr;
        logic        out_wr;     // Store saturated sum into an output lane.
        logic [1:0]  out_lane;
        logic        capture;    // Latch the input word.
    } dp_cmd_t;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -40'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage
`default_nettype wire

// ----- src/qmt_datapath.sv -----
// Datapath: input latch, matrix and scratch registers, one shared multiplier and accumulator.
// Depends on qmt_pkg.
`default_nettype none
module qmt_datapath
    import qmt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dp_cmd_t     cmd,
    input  wire logic [3:0]  in_index,
    input  wire logic [31:0] in_value,
    input  wire logic [31:0] in_qw,
    input  wire logic [31:0] in_qx,
    input  wire logic [31:0] in_qy,
    input  wire logic [31:0] in_qz,
    input  wire logic [31:0] in_px,
    input  wire logic [31:0] in_py,
    output logic [95:0]      out_word
);

    logic [3:0]         idx_reg;
    logic signed [31:0] val_reg, qw_reg, qx_reg, qy_reg, qz_reg, px_reg, py_reg;
    logic signed [31:0] mat_reg [MAT_DEPTH];
    logic signed [31:0] rot_reg [MAT_DEPTH];
    logic signed [31:0] res_reg [MAT_DEPTH];
    logic signed [31:0] prod_reg;
    logic signed [39:0] acc_reg, acc_next;
    logic signed [31:0] out_reg [3];
    logic signed [31:0] op_a, op_b, acc_sat, rot_rd;
    logic signed [63:0] full_prod, shifted;
    logic signed [39:0] addend;

    function automatic logic signed [31:0] pick(input msrc_t s, input logic signed [31:0] r,
                                                input logic signed [31:0] m,
                                                input logic signed [31:0] w,
                                                input logic signed [31:0] x,
                                                input logic signed [31:0] y,
                                                input logic signed [31:0] z,
                                                input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        case (s)
            MSRC_QW:  return w;
            MSRC_QX:  return x;
            MSRC_QY:  return y;
            MSRC_QZ:  return z;
            MSRC_PX:  return a;
            MSRC_PY:  return b;
            MSRC_ROT: return r;
            default:  return m;
        endcase
    endfunction

    always_comb
    begin
        // The fourth row and column of a rotation are fixed, so they are not stored.
        if (cmd.rot_idx == 4'd15)
            rot_rd = 32'sd1 <<< FRAC_BITS;
        else if (cmd.rot_idx[1:0] == 2'd3 || cmd.rot_idx[3:2] == 2'd3)
            rot_rd = 32'sd0;
        else
            rot_rd = rot_reg[cmd.rot_idx];
        op_a = pick(cmd.mul_a, rot_rd, mat_reg[cmd.mat_idx],
                    qw_reg, qx_reg, qy_reg, qz_reg, px_reg, py_reg);
        op_b = pick(cmd.mul_b, rot_rd, mat_reg[cmd.mat_idx],
                    qw_reg, qx_reg, qy_reg, qz_reg, px_reg, py_reg);
        full_prod = op_a * op_b;
        // Arithmetic shift rounds toward minus infinity.
        shifted = full_prod >>> FRAC_BITS;
        case (cmd.acc_src)
            ASRC_PROD:   addend = 40'(prod_reg);
            ASRC_PROD2:  addend = 40'(prod_reg) <<< 1;
            ASRC_NPROD2: addend = -(40'(prod_reg) <<< 1);
            ASRC_ONE:    addend = 40'sd1 <<< FRAC_BITS;
            ASRC_MAT:    addend = 40'(mat_reg[cmd.mat_idx]);
            default:     addend = '0;
        endcase
        acc_next = (cmd.acc_clr ? 40'sd0 : acc_reg) + addend;
        // Stores take the sum including this cycle's addend.
        acc_sat = sat32(acc_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAT_DEPTH; k++)
                mat_reg[k] <= ((k % 5) == 0) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
        end
        else if (cmd.load_wr)
            mat_reg[idx_reg] <= val_reg;
        else if (cmd.commit)
        begin
            for (int k = 0; k < MAT_DEPTH; k++)
                mat_reg[k] <= res_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg <= in_index;
            val_reg <= in_value;
            qw_reg  <= in_qw;
            qx_reg  <= in_qx;
            qy_reg  <= in_qy;
            qz_reg  <= in_qz;
            px_reg  <= in_px;
            py_reg  <= in_py;
        end
        if (cmd.mul_en)
            prod_reg <= sat32(40'(shifted > 64'sd2147483647 ? 64'sd2147483647 :
                              shifted < -64'sd2147483648 ? -64'sd2147483648 : shifted));
        if (cmd.acc_en)
            acc_reg <= acc_next;
        if (cmd.rot_wr)
            rot_reg[cmd.rot_wr_idx] <= acc_sat;
        if (cmd.res_wr)
            res_reg[cmd.res_wr_idx] <= acc_sat;
        if (cmd.out_wr)
            out_reg[cmd.out_lane] <= acc_sat;
    end

    assign out_word = {out_reg[2], out_reg[1], out_reg[0]};

endmodule
`default_nettype wire

// ----- src/qmt_ctrl.sv -----
// Controller: sequences loads, rotations and point transforms over the shared datapath.
// Depends on qmt_pkg.
`default_nettype none
module qmt_ctrl
    import qmt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] in_action,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    output dp_cmd_t         cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_QUAT  = 5'b00100,
        ST_MMUL  = 5'b01000,
        ST_XFORM = 5'b10000
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;

    // Inner product counter for the matrix multiply.
    logic [2:0] mm_k_reg;

    // Each term is a product issue followed by its accumulate step; a term sequence
    // for a rotation element: index of the product (0..8 = xx,yy,zz,xy,xz,yz,xw,yw,zw).
    // Rotation elements are built one at a time from a fixed recipe.
    typedef struct packed {
        logic [3:0] dst;
        logic       diag;       // One minus two terms, else two plus or minus.
        logic [3:0] pa;
        logic [3:0] pb;
        logic       neg_b;
    } rrec_t;

    function automatic rrec_t recipe(input logic [3:0] n);
        case (n)
            4'd0:    return '{4'd0,  1'b1, 4'd1, 4'd2, 1'b1};
            4'd1:    return '{4'd1,  1'b0, 4'd3, 4'd8, 1'b0};
            4'd2:    return '{4'd2,  1'b0, 4'd4, 4'd7, 1'b1};
            4'd3:    return '{4'd4,  1'b0, 4'd3, 4'd8, 1'b1};
            4'd4:    return '{4'd5,  1'b1, 4'd0, 4'd2, 1'b1};
            4'd5:    return '{4'd6,  1'b0, 4'd5, 4'd6, 1'b0};
            4'd6:    return '{4'd8,  1'b0, 4'd4, 4'd7, 1'b0};
            4'd7:    return '{4'd9,  1'b0, 4'd5, 4'd6, 1'b1};
            default: return '{4'd10, 1'b1, 4'd0, 4'd1, 1'b1};
        endcase
    endfunction

    function automatic logic [7:0] prod_ops(input logic [3:0] p);
        case (p)
            4'd0:    return {MSRC_QX, MSRC_QX};
            4'd1:    return {MSRC_QY, MSRC_QY};
            4'd2:    return {MSRC_QZ, MSRC_QZ};
            4'd3:    return {MSRC_QX, MSRC_QY};
            4'd4:    return {MSRC_QX, MSRC_QZ};
            4'd5:    return {MSRC_QY, MSRC_QZ};
            4'd6:    return {MSRC_QX, MSRC_QW};
            4'd7:    return {MSRC_QY, MSRC_QW};
            default: return {MSRC_QZ, MSRC_QW};
        endcase
    endfunction

    rrec_t      rr;
    logic [1:0] sub;
    logic [3:0] elem;
    logic [7:0] ops;
    logic [1:0] ri, rj;
    logic [2:0] kk;

    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg + 6'd1;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.mul_a      = MSRC_QW;
        cmd.mul_b      = MSRC_QW;
        cmd.acc_src    = ASRC_ZERO;
        rr   = recipe(step_reg[5:2]);
        sub  = step_reg[1:0];
        elem = step_reg[5:2];
        ops  = 8'd0;
        ri   = 2'd0;
        rj   = 2'd0;
        kk   = 3'd0;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = 6'd0;
                if (in_valid && in_ready)
                begin
                    cmd.capture = 1'b1;
                    unique case (action_t'(in_action))
                        ACT_LOAD:      state_next = ST_LOAD;
                        ACT_ROTATE:    state_next = ST_QUAT;
                        ACT_TRANSFORM: state_next = ST_XFORM;
                        default:       state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD:
            begin
                cmd.load_wr = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_QUAT:
            begin
                // Per element: product a plus base, product b while adding a, add b, store.
                unique case (sub)
                    2'd0:
                    begin
                        ops = prod_ops(rr.pa);
                        cmd.mul_en = 1'b1;
                        cmd.mul_a  = msrc_t'(ops[7:4]);
                        cmd.mul_b  = msrc_t'(ops[3:0]);
                        cmd.acc_en = 1'b1;
                        cmd.acc_clr = 1'b1;
                        cmd.acc_src = rr.diag ? ASRC_ONE : ASRC_ZERO;
                    end
                    2'd1:
                    begin
                        ops = prod_ops(rr.pb);
                        cmd.mul_en = 1'b1;
                        cmd.mul_a  = msrc_t'(ops[7:4]);
                        cmd.mul_b  = msrc_t'(ops[3:0]);
                        cmd.acc_en = 1'b1;
                        cmd.acc_src = rr.diag ? ASRC_NPROD2 : ASRC_PROD2;
                    end
                    2'd2:
                    begin
                        cmd.acc_en = 1'b1;
                        cmd.acc_src = rr.neg_b ? ASRC_NPROD2 : ASRC_PROD2;
                    end
                    default:
                    begin
                        cmd.rot_wr = 1'b1;
                        cmd.rot_wr_idx = rr.dst;
                        if (elem == 4'd8)
                        begin
                            state_next = ST_MMUL;
                            step_next  = 6'd0;
                        end
                    end
                endcase
            end
            ST_MMUL:
            begin
                // Element (i,j): products over k are issued for k=0..3 and accumulated in the cycle
                // after their issue, then the sum is stored.
                ri = step_reg[1:0];
                rj = step_reg[3:2];
                state_next = ST_MMUL;
                step_next = step_reg;
                kk = mm_k_reg;
                if (kk < 3'd4)
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_a   = MSRC_ROT;
                    cmd.mul_b   = MSRC_MAT;
                    cmd.rot_idx = {kk[1:0], ri};
                    cmd.mat_idx = {rj, kk[1:0]};
                end
                if (kk != 3'd0 && kk < 3'd5)
                begin
                    cmd.acc_en  = 1'b1;
                    cmd.acc_clr = (kk == 3'd1);
                    cmd.acc_src = ASRC_PROD;
                end
                if (kk == 3'd5)
                begin
                    cmd.res_wr = 1'b1;
                    cmd.res_wr_idx = {rj, ri};
                    step_next = step_reg + 6'd1;
                    if (step_reg[3:0] == 4'd15)
                    begin
                        cmd.commit = 1'b0;
                        state_next = ST_MMUL;
                        step_next  = 6'd16;
                    end
                end
                if (step_reg[4])
                begin
                    cmd = '0;
                    cmd.mul_a = MSRC_QW;
                    cmd.mul_b = MSRC_QW;
                    cmd.acc_src = ASRC_ZERO;
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_XFORM:
            begin
                // Per row: px product, py product while adding px, add translation,
                // add py and store.
                ri = step_reg[3:2];
                unique case (sub)
                    2'd0:
                    begin
                        cmd.mul_en = 1'b1;
                        cmd.mul_a = MSRC_MAT;
                        cmd.mul_b = MSRC_PX;
                        cmd.mat_idx = {2'd0, ri};
                        cmd.acc_en = 1'b1;
                        cmd.acc_clr = 1'b1;
                        cmd.acc_src = ASRC_ZERO;
                    end
                    2'd1:
                    begin
                        cmd.mul_en = 1'b1;
                        cmd.mul_a = MSRC_MAT;
                        cmd.mul_b = MSRC_PY;
                        cmd.mat_idx = {2'd1, ri};
                        cmd.acc_en = 1'b1;
                        cmd.acc_src = ASRC_PROD;
                    end
                    2'd2:
                    begin
                        cmd.acc_en = 1'b1;
                        cmd.acc_src = ASRC_PROD;
                    end
                    default:
                    begin
                        cmd.out_wr = 1'b1;
                        cmd.out_lane = ri;
                        cmd.acc_en = 1'b1;
                        cmd.acc_src = ASRC_PROD;
                        if (ri == 2'd2)
                        begin
                            state_next = ST_IDLE;
                            out_valid_next = 1'b1;
                        end
                    end
                endcase
                // The translation element is read in the third sub-step; the adder
                // stage swaps the matrix operand in for the product there.
                if (sub == 2'd2)
                begin
                    cmd.acc_src = ASRC_PROD;
                    cmd.mat_idx = {2'd3, ri};
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            mm_k_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_MMUL && mm_k_reg != 3'd5)
                mm_k_reg <= mm_k_reg + 3'd1;
            else
                mm_k_reg <= '0;
        end
    end

endmodule
`default_nettype wire

// ----- src/qmt_xadd.sv -----
// Translation adder stage: adds the translation column into the accumulator path.
// Depends on qmt_pkg.
`default_nettype none
module qmt_xadd
    import qmt_pkg::*;
(
    input  wire dp_cmd_t cmd_in,
    input  wire logic    xform,
    output dp_cmd_t      cmd_out
);

    // During a point transform the third sub-step adds the stored translation
    // element; the second product waits in the product register for the store step.
    always_comb
    begin
        cmd_out = cmd_in;
        if (xform && cmd_in.acc_en && cmd_in.mat_idx[3:2] == 2'd3)
            cmd_out.acc_src = ASRC_MAT;
    end

endmodule
`default_nettype wire

// ----- src/quaternion_matrix_transform.sv -----
// Top level of the quaternion matrix transform: controller plus datapath.
// Depends on qmt_pkg, qmt_ctrl, qmt_xadd and qmt_datapath.
//
// Usage: one input word per action on the s_axis channel. Load writes one element
// of the stored 4x4 Q16.16 matrix (index column*4 + row). Rotate builds the rotation
// matrix of the quaternion and premultiplies the stored matrix by it. Transform maps
// the point (point_x, point_y) and returns x, y and z as one word on m_axis.
// All work runs through one registered 32x32 multiplier and one 40-bit accumulator,
// with at most one product per cycle.
// A new word is taken only when the block is idle and no result waits, so a stalled
// receiver holds the result on m_axis_tdata and holds off the input side.
// Reset returns the matrix to identity and drops any pending result.
// Action code three is accepted and ignored.
`default_nettype none
module quaternion_matrix_transform
    import qmt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // Fields from bit 0: action[1:0], elem_index[5:2], elem_value[37:6],
    // quat_w[69:38], quat_x[101:70], quat_y[133:102], quat_z[165:134],
    // point_x[197:166], point_y[229:198], zero fill to 232 bits.
    input  wire logic [231:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // Fields from bit 0: out_x[31:0], out_y[63:32], out_z[95:64].
    output logic [95:0]       m_axis_tdata
);

    dp_cmd_t cmd_raw, cmd;
    logic    xform;

    qmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_action (s_axis_tdata[1:0]),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd_raw)
    );

    assign xform = cmd_raw.out_wr || (cmd_raw.mat_idx[3:2] == 2'd3 && !cmd_raw.mul_en
                                      && cmd_raw.acc_en && !cmd_raw.acc_clr);

    qmt_xadd u_xadd (
        .cmd_in  (cmd_raw),
        .xform   (xform),
        .cmd_out (cmd)
    );

    qmt_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_index (s_axis_tdata[5:2]),
        .in_value (s_axis_tdata[37:6]),
        .in_qw    (s_axis_tdata[69:38]),
        .in_qx    (s_axis_tdata[101:70]),
        .in_qy    (s_axis_tdata[133:102]),
        .in_qz    (s_axis_tdata[165:134]),
        .in_px    (s_axis_tdata[197:166]),
        .in_py    (s_axis_tdata[229:198]),
        .out_word (m_axis_tdata)
    );

`ifndef ASSERT_OFF
    a_no_take_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a result waits");
    a_commit_not_with_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.commit && cmd.load_wr))
        else $error("matrix commit and load in the same cycle");
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
`endif

endmodule
`default_nettype wire
